// ===== src/sas_pkg.sv =====
// Shared constants, command codes and divider interface types for the sprite sequencer.
`timescale 1ns / 1ps

package sas_pkg;

   localparam int MAX_FRAMES     = 256;
   localparam int MAX_FRAME_SIZE = 1024;

   localparam int CMD_W    = 3;
   localparam int MS_W     = 16;
   localparam int LOOP_W   = 9;
   localparam int FRAME_W  = 9;
   localparam int START_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int DELAY_W  = 16;
   localparam int COLS_W   = 9;
   localparam int SIZE_W   = 11;
   localparam int RECT_W   = 20;
   localparam int ACCUM_W  = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Divider operand widths: a dividend up to 512, a divisor up to 511.
   localparam int DVD_W     = 10;
   localparam int DVS_W     = 9;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PLAY_LOOPS = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PLAY_CONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET_FRAME  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_START_FRAME  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_DELAY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHEET_COLS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== src/sas_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
`timescale 1ns / 1ps

module sas_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sas_pkg::div_req_type div_req,
   output sas_pkg::div_rsp_type div_rsp
);
   import sas_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]     quot_ff, quot_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     divisor_ff, divisor_in;
   logic [DVS_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff, quot_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits in DVS_W bits.
         if (fits) begin
            rem_in = DVS_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[DVS_W-1:0];
         end
         quot_in = {quot_ff[DVD_W-2:0], fits};
         step_in = step_ff + DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   a_done_single_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

endmodule

// ===== src/sprite_animation_sequencer.sv =====
// Top level: command sequencer, configuration registers and sheet origin multiply.
//
//  Channel | Direction | Handshake             | Payload
//  req     | in        | req_valid/req_ready   | command, elapsed_ms, loop_count, frame_index
//  rsp     | out       | rsp_valid/rsp_ready   | rect_x, rect_y, current_frame, is_playing
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// An item that reduces a frame index modulo the frame count (frame advance or set frame)
// first waits in S_MOD for the modulo; every item then passes S_POS, S_POSW, S_MULX,
// S_MULY and S_DONE, where an output stall can hold it, before the next transfer.
// The 10-step serial divider runs once for the modulo and once for the sheet row and
// column; one multiplier then forms x in S_MULX and y in S_MULY.
// Reset is synchronous and clears state and configuration to their defaults.
// A finished result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module sprite_animation_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sas_pkg::CMD_W-1:0]          req_command,
   input  logic [sas_pkg::MS_W-1:0]           req_elapsed_ms,
   input  logic signed [sas_pkg::LOOP_W-1:0]  req_loop_count,
   input  logic [sas_pkg::FRAME_W-1:0]        req_frame_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sas_pkg::RECT_W-1:0]         rsp_rect_x,
   output logic [sas_pkg::RECT_W-1:0]         rsp_rect_y,
   output logic [sas_pkg::FRAME_W-1:0]        rsp_current_frame,
   output logic                               rsp_is_playing,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sas_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sas_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_POS  = 3'd2;
   localparam logic [2:0] S_POSW = 3'd3;
   localparam logic [2:0] S_MULX = 3'd4;
   localparam logic [2:0] S_MULY = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]           state_ff, state_in;

   logic [START_W-1:0]   start_ff, start_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [COLS_W-1:0]    cols_ff, cols_in;
   logic [SIZE_W-1:0]    width_ff, width_in;
   logic [SIZE_W-1:0]    height_ff, height_in;

   logic [ACCUM_W-1:0]   accum_ff, accum_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [LOOP_W-1:0]    loops_ff, loops_in;
   logic                 playing_ff, playing_in;
   logic                 stopping_ff, stopping_in;

   logic                 set_ff, set_in;
   logic                 neg_ff, neg_in;
   logic [COLS_W-1:0]    col_ff, col_in;
   logic [FRAME_W-1:0]   row_ff, row_in;
   logic [RECT_W-1:0]    rect_x_ff, rect_x_in;
   logic [RECT_W-1:0]    rect_y_ff, rect_y_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RECT_W-1:0]    rsp_x_ff, rsp_x_in;
   logic [RECT_W-1:0]    rsp_y_ff, rsp_y_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic                 rsp_playing_ff, rsp_playing_in;

   logic                 req_fire;
   logic [COUNT_W-1:0]   count_eff;
   logic [COLS_W-1:0]    cols_eff;
   logic [SIZE_W-1:0]    width_eff;
   logic [SIZE_W-1:0]    height_eff;
   logic [ACCUM_W-1:0]   accum_sum;
   logic                 tick_hit;
   logic [DVD_W:0]       adv_diff;
   logic [DVD_W:0]       adv_mag;
   logic                 adv_start;
   logic [COUNT_W-1:0]   residue;
   logic [FRAME_W-1:0]   next_frame;
   logic [FRAME_W-1:0]   mul_a;
   logic [SIZE_W-1:0]    mul_b;
   logic [RECT_W-1:0]    mul_prod;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   sas_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Register values outside their meaningful range are clamped here.
   assign count_eff  = (count_ff == '0) ? COUNT_W'(1) :
                       (count_ff > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : count_ff;
   assign cols_eff   = (cols_ff == '0) ? COLS_W'(1) : cols_ff;
   assign width_eff  = (width_ff > SIZE_W'(MAX_FRAME_SIZE)) ? SIZE_W'(MAX_FRAME_SIZE)
                                                           : width_ff;
   assign height_eff = (height_ff > SIZE_W'(MAX_FRAME_SIZE)) ? SIZE_W'(MAX_FRAME_SIZE)
                                                            : height_ff;

   assign accum_sum = accum_ff + {1'b0, req_elapsed_ms};
   assign tick_hit  = accum_sum >= {1'b0, delay_ff};

   // Offset of the next frame from the start frame; it is negative when the
   // frame after the current one lies below the start frame.
   assign adv_diff  = {2'b00, frame_ff} + (DVD_W+1)'(1) - {3'b000, start_ff};
   assign adv_mag   = adv_diff[DVD_W] ? (~adv_diff + (DVD_W+1)'(1)) : adv_diff;
   assign adv_start = (req_command == CMD_TICK) && playing_ff && tick_hit;

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = adv_mag[DVD_W-1:0];
      div_req.divisor  = count_eff;
      if (state_ff == S_POS) begin
         div_req.start    = 1'b1;
         div_req.dividend = {1'b0, frame_ff};
         div_req.divisor  = cols_eff;
      end else if (req_fire) begin
         if (req_command == CMD_SET_FRAME) begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, req_frame_index};
         end else if (adv_start) begin
            div_req.start = 1'b1;
         end
      end
   end

   // The nonnegative residue of a negative offset is the count less a nonzero remainder.
   assign residue    = (neg_ff && (div_rsp.remainder != '0)) ?
                       (count_eff - div_rsp.remainder) : div_rsp.remainder;
   assign next_frame = residue + {1'b0, start_ff};

   assign mul_a    = (state_ff == S_MULX) ? col_ff : row_ff;
   assign mul_b    = (state_ff == S_MULX) ? width_eff : height_eff;
   assign mul_prod = {11'd0, mul_a} * {9'd0, mul_b};

   always_comb begin
      state_in       = state_ff;
      start_in       = start_ff;
      count_in       = count_ff;
      delay_in       = delay_ff;
      cols_in        = cols_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      accum_in       = accum_ff;
      frame_in       = frame_ff;
      loops_in       = loops_ff;
      playing_in     = playing_ff;
      stopping_in    = stopping_ff;
      set_in         = set_ff;
      neg_in         = neg_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      rect_x_in      = rect_x_ff;
      rect_y_in      = rect_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_playing_in = rsp_playing_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_FRAME:  start_in  = csr_data[START_W-1:0];
            REG_FRAME_COUNT:  count_in  = csr_data[COUNT_W-1:0];
            REG_FRAME_DELAY:  delay_in  = csr_data[DELAY_W-1:0];
            REG_SHEET_COLS:   cols_in   = csr_data[COLS_W-1:0];
            REG_FRAME_WIDTH:  width_in  = csr_data[SIZE_W-1:0];
            REG_FRAME_HEIGHT: height_in = csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_POS;
               set_in   = 1'b0;
               neg_in   = adv_diff[DVD_W];
               case (req_command)
                  CMD_TICK: begin
                     if (playing_ff) begin
                        if (tick_hit) begin
                           accum_in = '0;
                           state_in = S_MOD;
                        end else begin
                           accum_in = accum_sum;
                        end
                     end
                  end
                  CMD_PLAY_LOOPS: begin
                     loops_in   = req_loop_count;
                     playing_in = 1'b1;
                  end
                  CMD_PLAY_CONT: begin
                     stopping_in = 1'b0;
                     playing_in  = 1'b1;
                     loops_in    = '1;
                  end
                  CMD_STOP: begin
                     stopping_in = playing_ff;
                  end
                  CMD_SET_FRAME: begin
                     set_in   = 1'b1;
                     state_in = S_MOD;
                  end
                  default: ;
               endcase
            end
         end
         S_MOD: begin
            if (div_rsp.done) begin
               state_in = S_POS;
               if (set_ff) begin
                  frame_in = div_rsp.remainder;
               end else begin
                  frame_in = next_frame;
                  // Arriving back at the start frame ends one loop of the sequence.
                  if (next_frame == {1'b0, start_ff}) begin
                     if (!loops_ff[LOOP_W-1]) begin
                        if (loops_ff != '0) begin
                           loops_in = loops_ff - LOOP_W'(1);
                        end else begin
                           playing_in = 1'b0;
                        end
                     end
                     if (stopping_ff) begin
                        stopping_in = 1'b0;
                        playing_in  = 1'b0;
                        loops_in    = '0;
                     end
                  end
               end
            end
         end
         S_POS: begin
            state_in = S_POSW;
         end
         S_POSW: begin
            if (div_rsp.done) begin
               col_in   = div_rsp.remainder;
               row_in   = div_rsp.quotient[FRAME_W-1:0];
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            rect_x_in = mul_prod;
            state_in  = S_MULY;
         end
         S_MULY: begin
            rect_y_in = mul_prod;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_x_in       = rect_x_ff;
               rsp_y_in       = rect_y_ff;
               rsp_frame_in   = frame_ff;
               rsp_playing_in = playing_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         count_ff     <= COUNT_W'(1);
         delay_ff     <= '0;
         cols_ff      <= COLS_W'(1);
         width_ff     <= SIZE_W'(32);
         height_ff    <= SIZE_W'(32);
         accum_ff     <= '0;
         frame_ff     <= '0;
         loops_ff     <= '0;
         playing_ff   <= 1'b0;
         stopping_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         delay_ff     <= delay_in;
         cols_ff      <= cols_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         accum_ff     <= accum_in;
         frame_ff     <= frame_in;
         loops_ff     <= loops_in;
         playing_ff   <= playing_in;
         stopping_ff  <= stopping_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff         <= set_in;
      neg_ff         <= neg_in;
      col_ff         <= col_in;
      row_ff         <= row_in;
      rect_x_ff      <= rect_x_in;
      rect_y_ff      <= rect_y_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_playing_ff <= rsp_playing_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rect_x        = rsp_x_ff;
   assign rsp_rect_y        = rsp_y_ff;
   assign rsp_current_frame = rsp_frame_ff;
   assign rsp_is_playing    = rsp_playing_ff;

   a_stop_needs_play: assert property (@(posedge clock) disable iff (reset)
      stopping_ff |-> playing_ff)
      else $error("stop pending while not playing");

   a_set_frame_in_range: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == S_MOD && div_rsp.done && set_ff) |-> (frame_ff < count_eff))
      else $error("set frame result not below frame count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result presented outside the completion state");

endmodule
